// File: design/srr_pkg.sv
package srr_pkg;

    localparam int SEQ_W = 32;
    localparam int TAG_W = 16;
    localparam int LEN_W = 9;
    localparam int WIN_W = 6;

    // Result kinds, carried on tuser
    localparam logic RESULT_ACK     = 1'b0;
    localparam logic RESULT_DELIVER = 1'b1;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd8;

    // Command queue between classifier and executor (depth is a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic             store;  // in-window packet: write slot and mark it
        logic             drain;  // packet sits at the base: deliver in order after store
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
    } cmd_t;

endpackage

// File: design/srr_queue.sv
module srr_queue
    import srr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic full,
    output logic empty
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // Advance pointers; depth is a power of two so they wrap on their own
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: design/srr_front.sv
module srr_front
    import srr_pkg::*;
#(
    parameter int BUFFER_DEPTH = 32,
    parameter int MAX_PAYLOAD  = 500
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [SEQ_W-1:0] in_seq,
    input  logic [TAG_W-1:0] in_tag,
    input  logic [LEN_W-1:0] in_len,
    input  logic             cfg_write,
    input  logic [WIN_W-1:0] cfg_window,
    input  logic [SEQ_W-1:0] receive_base,
    input  logic             drain_done,
    input  logic             queue_full,
    output logic             push,
    output cmd_t             push_cmd
);

    localparam logic [WIN_W-1:0] DEPTH_WIN = WIN_W'(BUFFER_DEPTH);

    logic [WIN_W-1:0] window_reg, window_next;
    logic             drain_pend_reg, drain_pend_next;
    logic [WIN_W-1:0] win_eff;
    logic [SEQ_W-1:0] ahead, behind, win_ext;
    logic             in_window, is_old, accept;
    logic [LEN_W-1:0] len_clamped;

    // Hold off while a drain may still move the base
    assign in_ready = !queue_full && !drain_pend_reg;
    assign accept   = in_valid && in_ready;

    // Clamp the window to [1, depth]
    always_comb begin
        if (window_reg == '0) begin
            win_eff = WIN_W'(1);
        end else if (window_reg > DEPTH_WIN) begin
            win_eff = DEPTH_WIN;
        end else begin
            win_eff = window_reg;
        end
    end

    // Classify against the base, modulo 2^32
    assign ahead     = in_seq - receive_base;
    assign behind    = receive_base - in_seq;
    assign win_ext   = SEQ_W'(win_eff);
    assign in_window = (ahead < win_ext);
    assign is_old    = (behind != '0) && (behind <= win_ext);

    // Limit the length to the largest payload
    assign len_clamped = (17'(in_len) > 17'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : in_len;

    // Build the command; dropped packets push nothing
    always_comb begin
        push           = accept && (in_window || is_old);
        push_cmd.store = in_window;
        push_cmd.drain = in_window && (ahead == '0);
        push_cmd.seq   = in_seq;
        push_cmd.tag   = in_tag;
        push_cmd.len   = len_clamped;
    end

    always_comb begin
        window_next     = cfg_write ? cfg_window : window_reg;
        drain_pend_next = drain_pend_reg;
        if (push && push_cmd.drain) begin
            drain_pend_next = 1'b1;
        end else if (drain_done) begin
            drain_pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg     <= WINDOW_RESET;
            drain_pend_reg <= 1'b0;
        end else begin
            window_reg     <= window_next;
            drain_pend_reg <= drain_pend_next;
        end
    end

endmodule

// File: design/srr_back.sv
module srr_back
    import srr_pkg::*;
#(
    parameter int BUFFER_DEPTH = 32
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             queue_empty,
    input  cmd_t             cmd,
    output logic             pop,
    output logic [SEQ_W-1:0] receive_base,
    output logic             drain_done,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_kind,
    output logic [SEQ_W-1:0] out_seq,
    output logic [TAG_W-1:0] out_tag,
    output logic [LEN_W-1:0] out_len,
    output logic             out_last
);

    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam logic [IDX_W:0]   DEPTH_SUM = (IDX_W+1)'(BUFFER_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(BUFFER_DEPTH - 1);

    typedef enum logic {ST_IDLE, ST_DRAIN} state_t;

    state_t                  state_reg, state_next;
    logic [SEQ_W-1:0]        base_reg, base_next;
    logic [IDX_W-1:0]        idx_reg, idx_next, idx_inc;
    logic [BUFFER_DEPTH-1:0] mark_reg, mark_next;
    logic                    valid_reg, valid_next;
    logic                    kind_reg, kind_next;
    logic [SEQ_W-1:0]        seq_reg, seq_next;
    logic [TAG_W-1:0]        tag_reg, tag_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic                    last_reg, last_next;

    logic [TAG_W-1:0]        tag_mem [BUFFER_DEPTH];
    logic [LEN_W-1:0]        len_mem [BUFFER_DEPTH];

    logic                    out_free, mem_write, mem_read;
    logic [SEQ_W-1:0]        ahead;
    logic [IDX_W:0]          slot_sum;
    logic [IDX_W-1:0]        slot;

    assign out_free = !valid_reg || out_ready;
    assign idx_inc  = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;

    // Slot of a stored packet: base slot plus offset, wrapped once
    assign ahead    = cmd.seq - base_reg;
    assign slot_sum = {1'b0, idx_reg} + {1'b0, ahead[IDX_W-1:0]};
    assign slot     = (slot_sum >= DEPTH_SUM) ? IDX_W'(slot_sum - DEPTH_SUM)
                                              : slot_sum[IDX_W-1:0];

    always_comb begin
        state_next = state_reg;
        base_next  = base_reg;
        idx_next   = idx_reg;
        mark_next  = mark_reg;
        valid_next = valid_reg && !out_ready;
        kind_next  = kind_reg;
        seq_next   = seq_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        mem_write  = 1'b0;
        mem_read   = 1'b0;
        drain_done = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // Take a command: store if in window, then send its ack
                if (!queue_empty && out_free) begin
                    pop        = 1'b1;
                    valid_next = 1'b1;
                    kind_next  = RESULT_ACK;
                    seq_next   = cmd.seq;
                    tag_next   = '0;
                    len_next   = '0;
                    last_next  = !cmd.drain;
                    if (cmd.store) begin
                        mem_write       = 1'b1;
                        mark_next[slot] = 1'b1;
                    end
                    if (cmd.drain) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                // Deliver the base slot, clear it and advance the base
                if (out_free) begin
                    valid_next         = 1'b1;
                    kind_next          = RESULT_DELIVER;
                    seq_next           = base_reg;
                    mem_read           = 1'b1;
                    last_next          = !mark_reg[idx_inc];
                    mark_next[idx_reg] = 1'b0;
                    base_next          = base_reg + 1'b1;
                    idx_next           = idx_inc;
                    if (!mark_reg[idx_inc]) begin
                        state_next = ST_IDLE;
                        drain_done = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            base_reg  <= '0;
            idx_reg   <= '0;
            mark_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            base_reg  <= base_next;
            idx_reg   <= idx_next;
            mark_reg  <= mark_next;
            valid_reg <= valid_next;
        end
        kind_reg <= kind_next;
        seq_reg  <= seq_next;
        last_reg <= last_next;
        // Load the payload of the base slot on a delivery
        if (mem_read) begin
            tag_reg <= tag_mem[idx_reg];
            len_reg <= len_mem[idx_reg];
        end else begin
            tag_reg <= tag_next;
            len_reg <= len_next;
        end
    end

    // Slot payload store
    always_ff @(posedge aclk) begin
        if (mem_write) begin
            tag_mem[slot] <= cmd.tag;
            len_mem[slot] <= cmd.len;
        end
    end

    assign receive_base = base_reg;
    assign out_valid    = valid_reg;
    assign out_kind     = kind_reg;
    assign out_seq      = seq_reg;
    assign out_tag      = tag_reg;
    assign out_len      = len_reg;
    assign out_last     = last_reg;

endmodule

// File: design/selective_repeat_receiver.sv
// An item's ack reaches m_tvalid through the command queue and the output register.
// Items that do not reach the base flow on unless m_tready stalls; one at the base blocks
// input until its in-order run is out, one delivery per cycle while m_tready allows.
// The executor emits at most one result per cycle through its output register.
// Reset (aresetn low, synchronous) clears base, received marks, queue and window (8)
// at once; slot payloads are not cleared and no clearing pass runs.
module selective_repeat_receiver
    import srr_pkg::*;
#(
    parameter int BUFFER_DEPTH = 32,
    parameter int MAX_PAYLOAD  = 500
)
(
    input  logic             aclk,
    input  logic             aresetn,
    // s_tdata: [31:0] sequence_number, [47:32] payload_tag, [56:48] payload_length
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,
    // m_tdata: [31:0] result_sequence, [47:32] result_tag, [56:48] result_length
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata,
    // m_tuser: [0] result_kind
    output logic             m_tuser,
    output logic             m_tlast,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [WIN_W-1:0] cfg_data
);

    logic             push, pop, q_full, q_empty, drain_done;
    cmd_t             push_cmd, pop_cmd;
    logic [SEQ_W-1:0] receive_base, out_seq;
    logic [TAG_W-1:0] out_tag;
    logic [LEN_W-1:0] out_len;

    assign cfg_ready = 1'b1;

    srr_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .MAX_PAYLOAD  (MAX_PAYLOAD)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_seq       (s_tdata[31:0]),
        .in_tag       (s_tdata[47:32]),
        .in_len       (s_tdata[56:48]),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_window   (cfg_data),
        .receive_base (receive_base),
        .drain_done   (drain_done),
        .queue_full   (q_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    srr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    srr_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .queue_empty  (q_empty),
        .cmd          (pop_cmd),
        .pop          (pop),
        .receive_base (receive_base),
        .drain_done   (drain_done),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_kind     (m_tuser),
        .out_seq      (out_seq),
        .out_tag      (out_tag),
        .out_len      (out_len),
        .out_last     (m_tlast)
    );

    assign m_tdata = {7'd0, out_len, out_tag, out_seq};

endmodule

// File: design/srr_checker.sv
module srr_checker
    import srr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 500
)
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // Acknowledgements carry no tag and no length
    a_ack_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == RESULT_ACK) |-> (m_tdata[56:32] == '0))
        else $error("ack with payload fields");

    // Delivered length never exceeds the largest payload
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (17'(m_tdata[56:48]) <= 17'(MAX_PAYLOAD)))
        else $error("delivered length above limit");

    // Reset empties the output register
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind selective_repeat_receiver srr_checker #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
) u_srr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
